>>> sv/cbm_pkg.sv
// Shared types, constants and helpers of the cartridge bank mapper.
package cbm_pkg;

  // Field widths
  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int TARGET_W    = 2;
  localparam int OFFSET_W    = 21;
  localparam int ROM_BANK_W  = 7;
  localparam int RAM_BANK_W  = 2;
  localparam int ROM_BANKS_W = 8;
  localparam int RAM_BYTES_W = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int ROM_PAGE_W  = 14;  // 16 KiB ROM bank
  localparam int RAM_PAGE_W  = 13;  // 8 KiB RAM bank
  localparam int RAM_OFF_W   = RAM_BANK_W + RAM_PAGE_W;

  // Result targets
  localparam logic [TARGET_W-1:0] TGT_NONE = 2'd0;
  localparam logic [TARGET_W-1:0] TGT_ROM  = 2'd1;
  localparam logic [TARGET_W-1:0] TGT_RAM  = 2'd2;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ROM_BANKS = 1'b0;
  localparam logic CFG_RAM_BYTES = 1'b1;

  // Control register regions, decoded from address bits 14:13 below 0x8000
  localparam logic [1:0] RGN_RAM_EN  = 2'b00;
  localparam logic [1:0] RGN_BANK_LO = 2'b01;
  localparam logic [1:0] RGN_BANK_HI = 2'b10;
  localparam logic [1:0] RGN_MODE    = 2'b11;

  // External RAM window 0xA000-0xBFFF, address bits 15:13
  localparam logic [2:0] EXT_RAM_PAGE = 3'b101;

  // Low nibble that turns external RAM on
  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

  localparam logic [ROM_BANKS_W-1:0] ROM_BANKS_RST = 8'd2;
  localparam logic [ROM_BANK_W-1:0]  ROM_BANK_RST  = 7'd1;

  typedef struct packed {
    logic                  opcode;
    logic [ADDR_W-1:0]     bus_address;
    logic [DATA_W-1:0]     write_value;
  } access_t;

  typedef struct packed {
    logic [TARGET_W-1:0]   target;
    logic [OFFSET_W-1:0]   phys_offset;
    logic                  ram_write;
  } result_t;

  typedef struct packed {
    logic                  ram_enable;
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic                  mode;
  } bank_state_t;

  // Mask a bank number to the ROM size; bank zero maps to one
  function automatic logic [ROM_BANK_W-1:0] bank_fix(
    input logic [ROM_BANK_W-1:0]  bank,
    input logic [ROM_BANKS_W-1:0] rom_banks
  );
    logic [ROM_BANK_W-1:0] mask;
    logic [ROM_BANK_W-1:0] masked;
    mask   = rom_banks[ROM_BANK_W-1:0] - ROM_BANK_W'(1);
    masked = bank & mask;
    return (masked == '0) ? ROM_BANK_W'(1) : masked;
  endfunction

endpackage

>>> sv/cbm_if.sv
// Valid/ready channel interfaces for bus accesses and mapping results.
interface cbm_req_if;
  import cbm_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] bus_address;
  logic [DATA_W-1:0] write_value;

  modport source (output valid, opcode, bus_address, write_value, input ready);
  modport sink   (input valid, opcode, bus_address, write_value, output ready);
endinterface

interface cbm_rsp_if;
  import cbm_pkg::*;
  logic                valid;
  logic                ready;
  logic [TARGET_W-1:0] target;
  logic [OFFSET_W-1:0] phys_offset;
  logic                ram_write;

  modport source (output valid, target, phys_offset, ram_write, input ready);
  modport sink   (input valid, target, phys_offset, ram_write, output ready);
endinterface

>>> sv/cbm_state.sv
// Banking control registers, updated by writes below 0x8000.
module cbm_state
  import cbm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   upd,
  input  access_t                acc,
  input  logic [ROM_BANKS_W-1:0] rom_banks,
  output bank_state_t            state
);

  bank_state_t state_next;
  logic        reg_write;

  assign reg_write = upd && (acc.opcode == OP_WRITE) && !acc.bus_address[ADDR_W-1];

  // Next state for a control register write
  always_comb begin
    state_next = state;
    if (reg_write) begin
      unique case (acc.bus_address[ADDR_W-2:ADDR_W-3])
        RGN_RAM_EN: begin
          state_next.ram_enable = (acc.write_value[3:0] == RAM_ENABLE_KEY);
        end
        RGN_BANK_LO: begin
          state_next.rom_bank = bank_fix(
            {state.rom_bank[6:5],
             (acc.write_value[4:0] == 5'd0) ? 5'd1 : acc.write_value[4:0]},
            rom_banks);
        end
        RGN_BANK_HI: begin
          if (state.mode) begin
            state_next.ram_bank = acc.write_value[RAM_BANK_W-1:0];
          end else begin
            state_next.rom_bank = bank_fix(
              {acc.write_value[RAM_BANK_W-1:0], state.rom_bank[4:0]}, rom_banks);
          end
        end
        RGN_MODE: begin
          state_next.mode = acc.write_value[0];
          if (!acc.write_value[0]) begin
            state_next.ram_bank = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.ram_enable <= 1'b0;
      state.rom_bank   <= ROM_BANK_RST;
      state.ram_bank   <= '0;
      state.mode       <= 1'b0;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/cbm_map.sv
// Address decode: picks ROM, RAM or open bus and forms the physical offset.
module cbm_map
  import cbm_pkg::*;
(
  input  access_t                acc,
  input  bank_state_t            state,
  input  logic [ROM_BANKS_W-1:0] rom_banks,
  input  logic [RAM_BYTES_W-1:0] ram_bytes,
  output result_t                res
);

  logic [RAM_OFF_W-1:0] ram_off;

  assign ram_off = {state.ram_bank, acc.bus_address[RAM_PAGE_W-1:0]};

  always_comb begin
    res = '{target: TGT_NONE, phys_offset: '0, ram_write: 1'b0};
    if (!acc.bus_address[ADDR_W-1]) begin
      // ROM window; writes here only touch control registers
      if (acc.opcode == OP_READ) begin
        if (!acc.bus_address[ROM_PAGE_W]) begin
          if (rom_banks != '0) begin
            res.target      = TGT_ROM;
            res.phys_offset = OFFSET_W'(acc.bus_address[ROM_PAGE_W-1:0]);
          end
        end else if ({1'b0, state.rom_bank} < rom_banks) begin
          res.target      = TGT_ROM;
          res.phys_offset = {state.rom_bank, acc.bus_address[ROM_PAGE_W-1:0]};
        end
      end
    end else if (acc.bus_address[ADDR_W-1:RAM_PAGE_W] == EXT_RAM_PAGE) begin
      // External RAM window, gated by enable and size
      if (state.ram_enable && (RAM_BYTES_W'(ram_off) < ram_bytes)) begin
        res.target      = TGT_RAM;
        res.phys_offset = OFFSET_W'(ram_off);
        res.ram_write   = (acc.opcode == OP_WRITE);
      end
    end
  end

endmodule

>>> sv/cartridge_bank_mapper_unit.sv
// Cartridge bank mapper: takes one bus access beat per cycle and returns one result beat for
// each, in order. An accepted access is held in an input register while the address decode
// and bank registers work on it. Its result is loaded into the output register once that
// register is free or draining, which sets the result beat valid. One access per cycle is
// sustained while the result side keeps taking beats. When the result side holds off, the
// block keeps up to two accesses (input and output register) before it drops req.ready.
// Control register writes (addresses below 0x8000) change the bank state at the edge that
// moves them to the output, so the following access already sees the new banks.
// Configuration (ROM bank count, RAM size) is written through cfg_we/cfg_index/cfg_data;
// the user must write it while no access is in flight, which the block does not enforce.
module cartridge_bank_mapper_unit
  import cbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cbm_req_if.sink               req,
  cbm_rsp_if.source             rsp
);

  logic                   acc_valid;
  access_t                acc_q;
  logic                   res_valid;
  result_t                res_q;
  result_t                res;
  logic                   advance;
  logic [ROM_BANKS_W-1:0] rom_banks;
  logic [RAM_BYTES_W-1:0] ram_bytes;
  bank_state_t            state;

  // Input stage moves on when the output register is free or draining
  assign advance   = acc_valid && (!res_valid || rsp.ready);
  assign req.ready = !acc_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (req.ready) begin
      acc_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      acc_q <= '{opcode: req.opcode, bus_address: req.bus_address,
                 write_value: req.write_value};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_banks <= ROM_BANKS_RST;
      ram_bytes <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROM_BANKS: rom_banks <= cfg_data[ROM_BANKS_W-1:0];
        CFG_RAM_BYTES: ram_bytes <= cfg_data[RAM_BYTES_W-1:0];
      endcase
    end
  end

  cbm_state u_state (
    .clk       (clk),
    .rst       (rst),
    .upd       (advance),
    .acc       (acc_q),
    .rom_banks (rom_banks),
    .state     (state)
  );

  cbm_map u_map (
    .acc       (acc_q),
    .state     (state),
    .rom_banks (rom_banks),
    .ram_bytes (ram_bytes),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.target      = res_q.target;
  assign rsp.phys_offset = res_q.phys_offset;
  assign rsp.ram_write   = res_q.ram_write;

`ifndef SYNTHESIS
  // Selected ROM bank is never zero
  a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (rst)
    state.rom_bank != '0)
    else $error("ROM bank register holds zero");

  // ROM banking mode keeps the RAM bank at zero
  a_mode0_ram_bank: assert property (@(posedge clk) disable iff (rst)
    !state.mode |-> state.ram_bank == '0)
    else $error("RAM bank nonzero in ROM banking mode");

  // Open bus results carry no offset and no write strobe
  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.target == TGT_NONE) |->
      (res_q.phys_offset == '0 && !res_q.ram_write))
    else $error("open bus result with offset or strobe");

  // RAM strobe only for RAM targets
  a_write_is_ram: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.ram_write) |-> res_q.target == TGT_RAM)
    else $error("RAM write strobe on non-RAM target");

  // Every advanced access shows a result at the next edge
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("accepted access produced no result");
`endif

endmodule
